// File: rtl/bbox_range_bearing_estimator_macros.svh
// assertion macros used by the checker file
`ifndef BBOX_RANGE_BEARING_ESTIMATOR_MACROS_SVH
`define BBOX_RANGE_BEARING_ESTIMATOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define BRBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define BRBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/brbe_pkg.sv
// shared constants and types for the range and bearing estimator
package brbe_pkg;

  localparam int NUM_CLASSES  = 8;
  localparam int REF_W        = 10;
  localparam int CFG_IDX_W    = 4;
  localparam int CLS_W        = 3;
  localparam int PIX_W        = 11;
  localparam int ANGLE_W      = 17;
  localparam int RANGE_W      = 27;
  localparam int POS_W        = 28;
  localparam int HALF_WIDTH   = 640;
  localparam int ABSD_W       = 10;
  localparam int CORDIC_ITERS = 24;
  localparam int CW           = 33;
  localparam int PROD_W       = 59;

  localparam logic [31:0] HALF_FOV_Q32  = 32'd4122872632;
  // bearing scale: divide by 640 * 2^16 = 5 * 2^23
  localparam logic [41:0] BEAR_HALF     = 42'd20971520;
  localparam logic [19:0] RECIP5_Q22    = 20'd838861;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  localparam logic [REF_W-1:0] REF_RESET [NUM_CLASSES] = '{
    10'd270, 10'd270, 10'd130, 10'd130, 10'd90, 10'd90, 10'd135, 10'd90
  };

  localparam logic [31:0] ATAN_Q30 [CORDIC_ITERS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // per-beat sideband that rides along the rotation pipeline
  typedef struct packed {
    logic [CLS_W-1:0]          cls;
    logic signed [ANGLE_W-1:0] angle;
    logic                      bad;
  } tag_t;

endpackage

// File: rtl/brbe_div.sv
// pipelined restoring divider, one quotient bit per stage
module brbe_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [brbe_pkg::RANGE_W-1:0]     num,
  input  logic [brbe_pkg::PIX_W-1:0]       den,
  output logic [brbe_pkg::RANGE_W-1:0]     quo
);

  localparam int N = brbe_pkg::RANGE_W;
  localparam int W = brbe_pkg::PIX_W;

  logic [N-1:0] num_r [N];
  logic [N-1:0] q_r   [N];
  logic [W-1:0] rem_r [N];
  logic [W-1:0] den_r [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [N-1:0] num_in;
      logic [N-1:0] q_in;
      logic [W-1:0] rem_in;
      logic [W-1:0] den_in;
      logic [W:0]   trial;
      logic         ge;

      if (k == 0) begin : g_first
        assign num_in = num;
        assign q_in   = '0;
        assign rem_in = '0;
        assign den_in = den;
      end else begin : g_next
        assign num_in = num_r[k-1];
        assign q_in   = q_r[k-1];
        assign rem_in = rem_r[k-1];
        assign den_in = den_r[k-1];
      end

      // shift in next numerator bit and try subtracting
      assign trial = {rem_in, num_in[N-1]};
      assign ge    = (trial >= {1'b0, den_in});

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[k] <= {num_in[N-2:0], 1'b0};
          q_r[k]   <= {q_in[N-2:0], ge};
          rem_r[k] <= ge ? W'(trial - {1'b0, den_in}) : W'(trial);
          den_r[k] <= den_in;
        end
      end
    end
  endgenerate

  assign quo = q_r[N-1];

endmodule

// File: rtl/brbe_cordic.sv
// pipelined rotation cordic, one iteration per stage, sideband carried along
module brbe_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  brbe_pkg::tag_t                    in_tag,
  input  logic signed [brbe_pkg::CW-1:0]    theta,
  output logic                              out_vld,
  output brbe_pkg::tag_t                    out_tag,
  output logic signed [brbe_pkg::CW-1:0]    cos_q30,
  output logic signed [brbe_pkg::CW-1:0]    sin_q30
);

  localparam int NI = brbe_pkg::CORDIC_ITERS;
  localparam int CW = brbe_pkg::CW;

  logic signed [CW-1:0] x_r [NI];
  logic signed [CW-1:0] y_r [NI];
  logic signed [CW-1:0] z_r [NI];
  logic                 vld_r [NI];
  brbe_pkg::tag_t       tag_r [NI];

  genvar i;
  generate
    for (i = 0; i < NI; i++) begin : g_iter
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [CW-1:0] z_in;
      logic                 v_in;
      brbe_pkg::tag_t       t_in;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;

      if (i == 0) begin : g_first
        assign x_in = brbe_pkg::CORDIC_GAIN_Q30;
        assign y_in = '0;
        assign z_in = theta;
        assign v_in = in_vld;
        assign t_in = in_tag;
      end else begin : g_next
        assign x_in = x_r[i-1];
        assign y_in = y_r[i-1];
        assign z_in = z_r[i-1];
        assign v_in = vld_r[i-1];
        assign t_in = tag_r[i-1];
      end

      // floor shifts and table angle
      assign dx = y_in >>> i;
      assign dy = x_in >>> i;
      assign at = $signed({1'b0, brbe_pkg::ATAN_Q30[i]});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          tag_r[i] <= t_in;
          if (!z_in[CW-1]) begin
            x_r[i] <= x_in - dx;
            y_r[i] <= y_in + dy;
            z_r[i] <= z_in - at;
          end else begin
            x_r[i] <= x_in + dx;
            y_r[i] <= y_in - dy;
            z_r[i] <= z_in + at;
          end
        end
      end
    end
  endgenerate

  assign out_vld = vld_r[NI-1];
  assign out_tag = tag_r[NI-1];
  assign cos_q30 = x_r[NI-1];
  assign sin_q30 = y_r[NI-1];

endmodule

// File: rtl/bbox_range_bearing_estimator.sv
// top level: range and bearing of a detection box, pipelined one beat per cycle when not stalled
//
// Takes one detection beat per cycle and returns one estimate beat per known class
// (0 to 7); classes 8 to 15 are taken and dropped. An accepted input beat passes one
// input stage, then the range divider (one quotient bit per stage) alongside three bearing
// stages and the 24-stage cordic, then two multiply stages and the output register.
// When a valid output beat is stalled the pipeline holds, except that a bubble in the last
// stage still lets everything behind it move forward. The user must write reference widths
// through the cfg port only while the pipeline is empty; the block does not enforce this.
// Indexes above 7 are ignored.
module bbox_range_bearing_estimator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [3:0]                             in_class_id,
  input  logic [brbe_pkg::PIX_W-1:0]             in_box_center,
  input  logic [brbe_pkg::PIX_W-1:0]             in_box_left,
  input  logic [brbe_pkg::PIX_W-1:0]             in_box_right,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [brbe_pkg::CLS_W-1:0]             out_class_out,
  output logic signed [brbe_pkg::ANGLE_W-1:0]    out_angle_out,
  output logic [brbe_pkg::RANGE_W-1:0]           out_range_out,
  output logic signed [brbe_pkg::POS_W-1:0]      out_x_out,
  output logic signed [brbe_pkg::POS_W-1:0]      out_y_out,
  output logic                                   out_bad_width,
  input  logic                                   cfg_we,
  input  logic [brbe_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [brbe_pkg::REF_W-1:0]             cfg_data
);

  localparam int CW = brbe_pkg::CW;
  localparam int PW = brbe_pkg::PROD_W;

  logic en_out;
  logic en;
  logic v_last;

  // reference width registers
  logic [brbe_pkg::REF_W-1:0] ref_r [brbe_pkg::NUM_CLASSES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < brbe_pkg::NUM_CLASSES; c++) ref_r[c] <= brbe_pkg::REF_RESET[c];
    end else if (cfg_we && (cfg_idx < brbe_pkg::CFG_IDX_W'(brbe_pkg::NUM_CLASSES))) begin
      ref_r[cfg_idx[brbe_pkg::CLS_W-1:0]] <= cfg_data;
    end
  end

  // pipeline moves unless a real result is blocked at the output
  assign en_out   = !out_valid || !out_stall;
  assign en       = en_out || !v_last;
  assign in_stall = !en;

  // stage 0: clamp center, box width, divider operands
  logic [brbe_pkg::PIX_W-1:0] center_c;
  logic signed [11:0]         d_c;
  logic signed [11:0]         width_c;
  logic                       bad_c;
  logic [brbe_pkg::PIX_W-1:0] w_c;

  assign center_c = (in_box_center > brbe_pkg::PIX_W'(2 * brbe_pkg::HALF_WIDTH)) ?
                    brbe_pkg::PIX_W'(2 * brbe_pkg::HALF_WIDTH) : in_box_center;
  assign d_c      = $signed({1'b0, center_c}) - $signed(12'(brbe_pkg::HALF_WIDTH));
  assign width_c  = $signed({1'b0, in_box_right}) - $signed({1'b0, in_box_left});
  assign bad_c    = (width_c <= 12'sd0);
  assign w_c      = bad_c ? brbe_pkg::PIX_W'(1) : width_c[brbe_pkg::PIX_W-1:0];

  logic                              vld0_r;
  logic [brbe_pkg::CLS_W-1:0]        cls0_r;
  logic [brbe_pkg::ABSD_W-1:0]       absd0_r;
  logic                              neg0_r;
  logic                              bad0_r;
  logic [brbe_pkg::PIX_W-1:0]        w0_r;
  logic [brbe_pkg::RANGE_W-1:0]      num0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid && !in_class_id[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls0_r  <= in_class_id[brbe_pkg::CLS_W-1:0];
      neg0_r  <= d_c[11];
      absd0_r <= d_c[11] ? brbe_pkg::ABSD_W'(-d_c) : brbe_pkg::ABSD_W'(d_c);
      bad0_r  <= bad_c;
      w0_r    <= w_c;
      num0_r  <= {ref_r[in_class_id[brbe_pkg::CLS_W-1:0]], 7'd0, 10'(w_c >> 1)};
    end
  end

  // range divider, aligned with the end of the cordic
  logic [brbe_pkg::RANGE_W-1:0] quo;

  brbe_div u_div (
    .clk (clk),
    .en  (en),
    .num (num0_r),
    .den (w0_r),
    .quo (quo)
  );

  // stage 1: bearing magnitude times half field of view, pre-shifted
  logic [41:0] bear_prod;
  assign bear_prod = 42'(absd0_r) * 42'(brbe_pkg::HALF_FOV_Q32) + brbe_pkg::BEAR_HALF;

  logic                       vld1_r;
  logic [brbe_pkg::CLS_W-1:0] cls1_r;
  logic                       neg1_r;
  logic                       bad1_r;
  logic [18:0]                v1_r;

  // stage 2: divide by five through the reciprocal
  logic [38:0] div5_prod;
  assign div5_prod = 39'(v1_r) * 39'(brbe_pkg::RECIP5_Q22);

  logic                              vld2_r;
  logic [brbe_pkg::CLS_W-1:0]        cls2_r;
  logic                              bad2_r;
  logic signed [brbe_pkg::ANGLE_W-1:0] angle2_r;

  // stage 3: angle to q30, negated
  logic                 vld3_r;
  brbe_pkg::tag_t       tag3_r;
  logic signed [CW-1:0] theta3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r   <= cls0_r;
      neg1_r   <= neg0_r;
      bad1_r   <= bad0_r;
      v1_r     <= bear_prod[41:23];
      cls2_r   <= cls1_r;
      bad2_r   <= bad1_r;
      angle2_r <= neg1_r ? -$signed({1'b0, div5_prod[37:22]})
                         :  $signed({1'b0, div5_prod[37:22]});
      tag3_r.cls   <= cls2_r;
      tag3_r.angle <= angle2_r;
      tag3_r.bad   <= bad2_r;
      theta3_r <= -(CW'(angle2_r) <<< 14);
    end
  end

  // rotation
  logic                 vld27;
  brbe_pkg::tag_t       tag27;
  logic signed [CW-1:0] cos27;
  logic signed [CW-1:0] sin27;

  brbe_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld3_r),
    .in_tag  (tag3_r),
    .theta   (theta3_r),
    .out_vld (vld27),
    .out_tag (tag27),
    .cos_q30 (cos27),
    .sin_q30 (sin27)
  );

  // stage 28: range times cos and sin in two halves each
  logic signed [14:0] rlo;
  logic signed [14:0] rhi;
  assign rlo = $signed({1'b0, quo[13:0]});
  assign rhi = $signed({2'b00, quo[26:14]});

  logic                          vld28_r;
  brbe_pkg::tag_t                tag28_r;
  logic [brbe_pkg::RANGE_W-1:0]  rng28_r;
  logic signed [47:0]            pxl_r;
  logic signed [47:0]            pxh_r;
  logic signed [47:0]            pyl_r;
  logic signed [47:0]            pyh_r;

  // stage 29: recombine halves
  logic                          vld29_r;
  brbe_pkg::tag_t                tag29_r;
  logic [brbe_pkg::RANGE_W-1:0]  rng29_r;
  logic signed [PW-1:0]          px29_r;
  logic signed [PW-1:0]          py29_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld28_r <= 1'b0;
      vld29_r <= 1'b0;
    end else if (en) begin
      vld28_r <= vld27;
      vld29_r <= vld28_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag28_r <= tag27;
      rng28_r <= quo;
      pxl_r   <= 48'(rlo) * 48'(cos27);
      pxh_r   <= 48'(rhi) * 48'(cos27);
      pyl_r   <= 48'(rlo) * 48'(sin27);
      pyh_r   <= 48'(rhi) * 48'(sin27);
      tag29_r <= tag28_r;
      rng29_r <= rng28_r;
      px29_r  <= (PW'(pxh_r) <<< 14) + PW'(pxl_r);
      py29_r  <= (PW'(pyh_r) <<< 14) + PW'(pyl_r);
    end
  end

  assign v_last = vld29_r;

  // output register: round to nearest, ties away from zero
  logic signed [PW-1:0] xr;
  logic signed [PW-1:0] yr;
  assign xr = px29_r + PW'(64'sd536870912) - PW'({1'b0, px29_r[PW-1]});
  assign yr = py29_r + PW'(64'sd536870912) - PW'({1'b0, py29_r[PW-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= vld29_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_class_out <= tag29_r.cls;
      out_angle_out <= tag29_r.angle;
      out_bad_width <= tag29_r.bad;
      out_range_out <= tag29_r.bad ? '0 : rng29_r;
      out_x_out     <= tag29_r.bad ? '0 : xr[57:30];
      out_y_out     <= tag29_r.bad ? '0 : yr[57:30];
    end
  end

endmodule

// File: rtl/brbe_checker.sv
// port-level checker for the estimator, bound to the top level
`include "bbox_range_bearing_estimator_macros.svh"

module brbe_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [brbe_pkg::ANGLE_W-1:0] out_angle_out,
  input logic [brbe_pkg::RANGE_W-1:0]        out_range_out,
  input logic signed [brbe_pkg::POS_W-1:0]   out_x_out,
  input logic signed [brbe_pkg::POS_W-1:0]   out_y_out,
  input logic                                out_bad_width
);

  // a stalled result beat stays offered
  `BRBE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // input side never stalls while the output side is free
  `BRBE_ASSERT_IMPL(a_flow, clk, rst_n, !out_stall, !in_stall)

  // bad width beats carry a zeroed range and position
  `BRBE_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_valid && out_bad_width,
    (out_range_out == '0) && (out_x_out == '0) && (out_y_out == '0))

  // bearing stays within half the field of view
  `BRBE_ASSERT_IMPL(a_angle, clk, rst_n, out_valid,
    (out_angle_out <= 17'sd62915) && (out_angle_out >= -17'sd62915))

endmodule

bind bbox_range_bearing_estimator brbe_checker u_brbe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_angle_out (out_angle_out),
  .out_range_out (out_range_out),
  .out_x_out     (out_x_out),
  .out_y_out     (out_y_out),
  .out_bad_width (out_bad_width)
);
